// ===== design/uirp_pkg.sv =====
`default_nettype none
package uirp_pkg;

  localparam int BUF_DEPTH_DEF = 32;

  localparam int PERIOD_W  = 17;
  localparam int TIMEOUT_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;
  localparam int PHASE_W   = 4;
  localparam int LEN_W     = 6;

  localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 17'd16;
  localparam logic                 RX_EN_RST   = 1'b1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd1000;
  localparam logic [TIMEOUT_W-1:0] IDLE_MAX    = {TIMEOUT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RX_ENABLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd2;

  localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
  localparam logic [PHASE_W-1:0] PH_START = 4'd1;
  localparam logic [PHASE_W-1:0] PH_DATA0 = 4'd2;
  localparam logic [PHASE_W-1:0] PH_STOP  = 4'd10;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_PKT   = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_RD,
    ST_LD
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic ld_mark;
    logic ld_pkt;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic dump_req;
    logic dump_empty;
    logic idx_last;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== design/uirp_ctrl.sv =====
`default_nettype none
module uirp_ctrl import uirp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.out_free && sts.dump_req) begin
          state_nxt = sts.dump_empty ? ST_MARK : ST_RD;
        end
      end
      ST_MARK: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_RD: state_nxt = ST_LD;
      ST_LD: begin
        if (sts.out_free) state_nxt = sts.idx_last ? ST_IDLE : ST_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !sts.out_free;
        cmd.take = in_valid && sts.out_free;
      end
      ST_MARK: cmd.ld_mark = sts.out_free;
      ST_RD:   cmd = '0;
      ST_LD:   cmd.ld_pkt = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/uirp_dp.sv =====
`default_nettype none
module uirp_dp import uirp_pkg::*; #(
  parameter int BUFFER_DEPTH = BUF_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  input  wire logic                 in_rx_level,
  input  wire logic                 in_fetch_poll,
  input  wire dp_cmd_t              cmd,
  output dp_sts_t                   sts,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_data,
  output logic [LEN_W-1:0]          out_packet_length,
  output logic                      out_overflow,
  output logic                      out_last
);

  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [PERIOD_W-1:0]  bit_period_r;
  logic                 rx_en_r;
  logic [TIMEOUT_W-1:0] timeout_r;

  logic                 prev_r, prev_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [PERIOD_W-1:0]  tick_r, tick_nxt;
  logic [7:0]           shift_r, shift_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 armed_r, armed_nxt;
  logic [TIMEOUT_W-1:0] idle_r, idle_nxt;
  logic [CW-1:0]        len_r, idx_r;
  logic [7:0]           rdata_r;
  logic [7:0]           mem [BUFFER_DEPTH];

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           kind_r;
  logic [7:0]           data_r;
  logic [LEN_W-1:0]     plen_r;
  logic                 ovf_r, last_r;

  logic          fire, good, has_room, store, ovf, dump;
  logic [CW-1:0] cnt_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= PERIOD_RST;
      rx_en_r      <= RX_EN_RST;
      timeout_r    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIT_PERIOD: bit_period_r <= cfg_data[PERIOD_W-1:0];
        REG_RX_ENABLE:  rx_en_r      <= cfg_data[0];
        REG_TIMEOUT:    timeout_r    <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    idle_nxt  = (idle_r == IDLE_MAX) ? idle_r : idle_r + 24'd1;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    shift_nxt = shift_r;
    fire      = 1'b0;
    good      = 1'b0;
    if (phase_r != PH_IDLE) begin
      if (tick_r <= 17'd1) begin
        fire     = 1'b1;
        tick_nxt = bit_period_r;
      end else begin
        tick_nxt = tick_r - 17'd1;
      end
      if (fire) begin
        if (phase_r == PH_START) begin
          phase_nxt = PH_DATA0;
        end else if (phase_r < PH_STOP) begin
          shift_nxt = {in_rx_level, shift_r[7:1]};
          phase_nxt = phase_r + 4'd1;
        end else begin
          phase_nxt = PH_IDLE;
          good      = (phase_r == PH_STOP) && in_rx_level;
        end
      end
    end else if (prev_r && !in_rx_level && rx_en_r) begin
      phase_nxt = PH_START;
      shift_nxt = 8'd0;
      tick_nxt  = bit_period_r >> 1;
    end
    prev_nxt  = in_rx_level;
    has_room  = count_r < CW'(BUFFER_DEPTH);
    store     = good && has_room;
    ovf       = good && !has_room && armed_r;
    cnt_after = store ? count_r + CW'(1) : count_r;
    if (good) idle_nxt = '0;
    dump      = in_fetch_poll && (idle_nxt >= timeout_r);
    count_nxt = dump ? '0 : cnt_after;
    armed_nxt = dump ? 1'b0 : (in_fetch_poll | armed_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b1;
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      shift_r <= '0;
      count_r <= '0;
      armed_r <= 1'b0;
      idle_r  <= '0;
    end else if (cmd.take) begin
      prev_r  <= prev_nxt;
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      shift_r <= shift_nxt;
      count_r <= count_nxt;
      armed_r <= armed_nxt;
      idle_r  <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && store) mem[count_r[AW-1:0]] <= shift_r;
    rdata_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      len_r <= cnt_after;
      idx_r <= '0;
    end else if (cmd.ld_pkt) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if ((cmd.take && good) || cmd.ld_mark || cmd.ld_pkt) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && good) begin
      kind_r <= KIND_BYTE;
      data_r <= shift_r;
      plen_r <= '0;
      ovf_r  <= ovf;
      last_r <= !dump;
    end else if (cmd.ld_mark) begin
      kind_r <= KIND_EMPTY;
      data_r <= '0;
      plen_r <= '0;
      ovf_r  <= 1'b0;
      last_r <= 1'b1;
    end else if (cmd.ld_pkt) begin
      kind_r <= KIND_PKT;
      data_r <= rdata_r;
      plen_r <= LEN_W'(len_r);
      ovf_r  <= 1'b0;
      last_r <= sts.idx_last;
    end
  end

  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.dump_req   = dump;
  assign sts.dump_empty = (cnt_after == '0);
  assign sts.idx_last   = (idx_r == len_r - CW'(1));

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_data          = data_r;
  assign out_packet_length = plen_r;
  assign out_overflow      = ovf_r;
  assign out_last          = last_r;

endmodule
`default_nettype wire

// ===== design/uart_rx_with_idle_packet.sv =====
// Channel   Handshake           Payload
// in_       in_valid/in_stall   in_rx_level, in_fetch_poll
// out_      out_valid/out_stall out_kind, out_data, out_packet_length,
//                               out_overflow, out_last
// cfg_      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One sample per cycle while the result register is free and no packet dump
// runs; a received byte sits in the single result register, so the next
// sample otherwise waits only for it. A packet dump holds input while each
// stored byte is read from the buffer then loaded, or the empty marker is.
// Reset is synchronous on rst_n low; cfg_ready is always high.
`default_nettype none
module uart_rx_with_idle_packet import uirp_pkg::*; #(
  parameter int BUFFER_DEPTH = BUF_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_rx_level,
  input  wire logic                 in_fetch_poll,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_data,
  output logic [LEN_W-1:0]          out_packet_length,
  output logic                      out_overflow,
  output logic                      out_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  uirp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  uirp_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_rx_level       (in_rx_level),
    .in_fetch_poll     (in_fetch_poll),
    .cmd               (cmd),
    .sts               (sts),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_data          (out_data),
    .out_packet_length (out_packet_length),
    .out_overflow      (out_overflow),
    .out_last          (out_last)
  );

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take, cmd.ld_mark, cmd.ld_pkt}))
    else $error("more than one result load in a cycle");

  a_ovf_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_kind == KIND_BYTE)
    else $error("overflow flagged on a packet result");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EMPTY |-> out_last && out_data == 8'd0)
    else $error("empty marker not final or carries data");

  a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> !$past(out_valid && out_stall))
    else $error("transaction accepted over a held result");

endmodule
`default_nettype wire

// ===== test/uart_rx_with_idle_packet_test.sv =====
`timescale 1ns / 1ps
module uart_rx_with_idle_packet_test;
  import uirp_pkg::*;

  localparam int DEPTH = BUF_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int QUIET_CYCLES = 8;
  localparam int REPORT_MAX = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    kind_t            kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             ovf;
    logic             last;
  } rx_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_rx_level;
  logic                 in_fetch_poll;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_kind;
  logic [7:0]           out_data;
  logic [LEN_W-1:0]     out_packet_length;
  logic                 out_overflow;
  logic                 out_last;

  // receiver model state
  logic [PERIOD_W-1:0]  m_period;
  logic                 m_rx_en;
  logic [TIMEOUT_W-1:0] m_timeout;
  logic                 m_prev;
  logic [PHASE_W-1:0]   m_phase;
  logic [PERIOD_W-1:0]  m_count;
  logic [7:0]           m_shift;
  logic [7:0]           m_store [DEPTH];
  int                   m_fill;
  logic                 m_armed;
  logic [TIMEOUT_W-1:0] m_idle;

  rx_result_t pending_results[$];

  int  cycles = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  gaps_on = 1'b1;
  int  poll_pct = 0;
  bit  poll_on_stop = 1'b0;

  uart_rx_with_idle_packet i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_level       (in_rx_level),
    .in_fetch_poll     (in_fetch_poll),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data          (out_data),
    .out_packet_length (out_packet_length),
    .out_overflow      (out_overflow),
    .out_last          (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("uart_rx_with_idle_packet verification failed");
      $finish;
    end
  end

  function automatic void reset_model();
    m_period  = PERIOD_RST;
    m_rx_en   = RX_EN_RST;
    m_timeout = TIMEOUT_RST;
    m_prev    = 1'b1;
    m_phase   = PH_IDLE;
    m_count   = '0;
    m_shift   = '0;
    m_fill    = 0;
    m_armed   = 1'b0;
    m_idle    = '0;
  endfunction

  // one line sample: advance the receiver and queue what it emits
  function automatic void receive_sample(logic level, logic poll);
    rx_result_t batch[$];
    rx_result_t r;
    logic       fire;
    if (m_idle != IDLE_MAX) m_idle++;
    if (m_phase != PH_IDLE) begin
      fire = (m_count <= 1);
      if (fire) m_count = m_period;
      else m_count--;
      if (fire) begin
        if (m_phase == PH_START) begin
          m_phase = PH_DATA0;
        end else if (m_phase < PH_STOP) begin
          m_shift = {level, m_shift[7:1]};
          m_phase = m_phase + 1'b1;
        end else if (m_phase == PH_STOP) begin
          m_phase = PH_IDLE;
          if (level) begin
            r = '{KIND_BYTE, m_shift, '0, 1'b0, 1'b0};
            if (m_fill < DEPTH) begin
              m_store[m_fill] = m_shift;
              m_fill++;
            end else begin
              r.ovf = m_armed;
            end
            m_idle = '0;
            batch.push_back(r);
          end
        end else begin
          m_phase = PH_IDLE;
        end
      end
    end else if (m_prev && !level && m_rx_en) begin
      m_phase = PH_START;
      m_shift = '0;
      m_count = m_period >> 1;
    end
    m_prev = level;
    if (poll) begin
      m_armed = 1'b1;
      if (m_idle >= m_timeout) begin
        if (m_fill == 0) begin
          batch.push_back('{KIND_EMPTY, 8'h00, '0, 1'b0, 1'b0});
        end else begin
          for (int i = 0; i < m_fill; i++)
            batch.push_back('{KIND_PKT, m_store[i], LEN_W'(m_fill), 1'b0, 1'b0});
        end
        m_fill  = 0;
        m_armed = 1'b0;
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endfunction

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    rx_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected transaction: kind %0d data %02h len %0d ovf %0b last %0b",
                   out_kind, out_data, out_packet_length, out_overflow, out_last);
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind || out_data !== want.data ||
            out_packet_length !== want.len || out_overflow !== want.ovf ||
            out_last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $write("mismatch: expected kind %0d data %02h len %0d ovf %0b last %0b,",
                   want.kind, want.data, want.len, want.ovf, want.last);
            $display(" got kind %0d data %02h len %0d ovf %0b last %0b",
                     out_kind, out_data, out_packet_length, out_overflow, out_last);
          end
        end
      end
      stall_left = gaps_on ? $urandom_range(0, 6) : 0;
    end
  end

  task automatic send_sample(logic level, logic poll);
    int gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_rx_level   <= level;
    in_fetch_poll <= poll;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    receive_sample(level, poll);
  endtask

  function automatic logic pick_poll();
    return ($urandom_range(0, 99) < poll_pct) ||
           (poll_on_stop && m_phase == PH_STOP && m_count <= 1);
  endfunction

  task automatic send_level(logic level, int n);
    repeat (n) send_sample(level, pick_poll());
  endtask

  task automatic send_frame(logic [7:0] value, logic stop, int sp);
    send_level(1'b1, $urandom_range(1, 3));
    send_level(1'b0, sp);
    for (int i = 0; i < 8; i++) send_level(value[i], sp);
    send_level(stop, sp);
  endtask

  // input idle and every expected transaction in before any register write
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BIT_PERIOD: m_period = value[PERIOD_W-1:0];
      REG_RX_ENABLE:  m_rx_en = value[0];
      REG_TIMEOUT:    m_timeout = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(int period, bit enable, int timeout);
    drain();
    write_reg(REG_BIT_PERIOD, CFG_DAT_W'(period));
    write_reg(REG_RX_ENABLE, CFG_DAT_W'(enable));
    write_reg(REG_TIMEOUT, CFG_DAT_W'(timeout));
  endtask

  task automatic test_reset_values();
    gaps_on  = 1'b1;
    poll_pct = 0;
    send_frame(8'hA5, 1'b1, 16);
    send_sample(1'b1, 1'b1);
    gaps_on = 1'b0;
    send_level(1'b1, 1000);
    send_sample(1'b1, 1'b1);
    gaps_on = 1'b1;
    drain();
  endtask

  task automatic test_config_extremes();
    configure(2, 1'b1, 0);
    send_sample(1'b1, 1'b1);
    send_frame(8'h00, 1'b1, 2);
    send_frame(8'hFF, 1'b1, 2);
    send_frame(8'h5A, 1'b0, 2);
    poll_on_stop = 1'b1;
    send_frame(8'h3C, 1'b1, 2);
    poll_on_stop = 1'b0;
    drain();
    write_reg(REG_UNUSED, 24'hFFFFFF);
    write_reg(REG_BIT_PERIOD, 24'hFE0003);
    send_frame(8'h81, 1'b1, 3);
    drain();
    write_reg(REG_BIT_PERIOD, 24'h000001);
    send_frame(8'hC3, 1'b1, 1);
    drain();
    write_reg(REG_BIT_PERIOD, 24'h000000);
    send_frame(8'h96, 1'b1, 1);
    send_sample(1'b1, 1'b1);
    drain();
    write_reg(REG_BIT_PERIOD, 24'h010000);
    send_level(1'b1, 5);
    send_sample(1'b1, 1'b1);
    drain();
    write_reg(REG_BIT_PERIOD, 24'hFFFFFF);
    send_level(1'b1, 5);
    drain();
    write_reg(REG_TIMEOUT, 24'hFFFFFF);
    send_sample(1'b1, 1'b1);
    configure(4, 1'b1, 0);
    send_sample(1'b1, 1'b1);
  endtask

  task automatic test_enable();
    configure(3, 1'b0, 0);
    send_frame(8'h55, 1'b1, 3);
    drain();
    write_reg(REG_RX_ENABLE, 24'h000001);
    send_level(1'b1, 2);
    send_level(1'b0, 3);
    for (int i = 0; i < 4; i++) send_level(1'b1 ^ i[0], 3);
    drain();
    // frame already under way carries on with starts blocked
    write_reg(REG_RX_ENABLE, 24'h000000);
    for (int i = 4; i < 8; i++) send_level(i[1], 3);
    send_level(1'b1, 5);
    send_sample(1'b1, 1'b1);
    send_frame(8'h18, 1'b1, 3);
    send_sample(1'b1, 1'b1);
    drain();
    write_reg(REG_RX_ENABLE, 24'h000001);
  endtask

  task automatic test_timeout_boundary();
    configure(2, 1'b1, 5);
    send_frame(8'h42, 1'b1, 2);
    repeat (7) send_sample(1'b1, 1'b1);
  endtask

  task automatic test_overflow();
    configure(2, 1'b1, 'hFFFFFF);
    repeat (DEPTH + 1) send_frame(8'($urandom_range(0, 255)), 1'b1, 2);
    send_sample(1'b1, 1'b1);
    send_frame(8'($urandom_range(0, 255)), 1'b1, 2);
    drain();
    write_reg(REG_TIMEOUT, 24'h000000);
    poll_on_stop = 1'b1;
    send_frame(8'($urandom_range(0, 255)), 1'b1, 2);
    poll_on_stop = 1'b0;
  endtask

  task automatic test_backpressure();
    configure(2, 1'b1, 0);
    gaps_on   = 1'b0;
    hold_left = 400;
    repeat (2) begin
      repeat (4) send_frame(8'($urandom_range(0, 255)), 1'b1, 2);
      poll_on_stop = 1'b1;
      send_frame(8'($urandom_range(0, 255)), 1'b1, 2);
      poll_on_stop = 1'b0;
    end
    gaps_on   = 1'b1;
    hold_left = 250;
    repeat (DEPTH) send_frame(8'($urandom_range(0, 255)), 1'b1, 2);
    send_sample(1'b1, 1'b1);
  endtask

  task automatic test_random_traffic();
    int first_sample;
    int period;
    int sp;
    int pick;
    int timeout;
    first_sample = samples_sent;
    while (samples_sent - first_sample < 250) begin
      period = $urandom_range(2, 8);
      case ($urandom_range(0, 3))
        0: timeout = 0;
        1: timeout = $urandom_range(1, 30);
        2: timeout = $urandom_range(30, 200);
        default: timeout = $urandom_range(200, 2000);
      endcase
      configure(period, $urandom_range(0, 7) != 0, timeout);
      gaps_on      = $urandom_range(0, 3) != 0;
      poll_pct     = $urandom_range(0, 6);
      poll_on_stop = $urandom_range(0, 3) == 0;
      repeat ($urandom_range(3, 8)) begin
        sp   = ($urandom_range(0, 4) == 0) ? period + $urandom_range(0, 2) - 1 : period;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(0, 1)), pick_poll());
        end else begin
          send_frame(8'($urandom_range(0, 255)), pick != 1, sp);
        end
      end
      send_level(1'b1, $urandom_range(0, 40));
    end
    poll_pct     = 0;
    poll_on_stop = 1'b0;
    gaps_on      = 1'b1;
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_rx_level   = 1'b1;
    in_fetch_poll = 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_config_extremes();
    test_enable();
    test_timeout_boundary();
    test_overflow();
    test_backpressure();
    test_random_traffic();

    drain();
    repeat (20) @(posedge clk);
    $display("%0d line samples sent, %0d transactions checked, %0d mismatches",
             samples_sent, results_seen, mismatches);
    $display("covered defaults, config extremes, enable, overflow, long holds, random frames");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("uart_rx_with_idle_packet verification clean");
    end else begin
      $display("uart_rx_with_idle_packet verification failed");
    end
    $finish;
  end

endmodule
